FILE: rtl/cpu16_pkg.sv
package cpu16_pkg;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_HALT        = 3'd1,
    ST_EXEC_DATA   = 3'd2,
    ST_PRIV        = 3'd3,
    ST_LOAD_FAULT  = 3'd4,
    ST_STORE_FAULT = 3'd5,
    ST_BAD_OP      = 3'd6,
    ST_LOADED      = 3'd7
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_FETCH, S_RS, S_RT, S_RD, S_EXEC, S_DIV, S_LOAD, S_OUT
  } state_t;

  localparam logic [3:0] OP_BR      = 4'd0;
  localparam logic [3:0] OP_ARITH   = 4'd1;
  localparam logic [3:0] OP_CMP     = 4'd2;
  localparam logic [3:0] OP_JSR     = 4'd4;
  localparam logic [3:0] OP_LOGIC   = 4'd5;
  localparam logic [3:0] OP_LDR     = 4'd6;
  localparam logic [3:0] OP_STR     = 4'd7;
  localparam logic [3:0] OP_RTI     = 4'd8;
  localparam logic [3:0] OP_CONST   = 4'd9;
  localparam logic [3:0] OP_SHIFT   = 4'd10;
  localparam logic [3:0] OP_JMP     = 4'd12;
  localparam logic [3:0] OP_HICONST = 4'd13;
  localparam logic [3:0] OP_TRAP    = 4'd15;

  localparam logic [1:0] SUB_ADD = 2'd0;
  localparam logic [1:0] SUB_MUL = 2'd1;
  localparam logic [1:0] SUB_SUB = 2'd2;
  localparam logic [1:0] SUB_DIV = 2'd3;
  localparam logic [1:0] SUB_AND = 2'd0;
  localparam logic [1:0] SUB_NOT = 2'd1;
  localparam logic [1:0] SUB_OR  = 2'd2;
  localparam logic [1:0] SUB_XOR = 2'd3;
  localparam logic [1:0] SUB_CMP   = 2'd0;
  localparam logic [1:0] SUB_CMPU  = 2'd1;
  localparam logic [1:0] SUB_CMPI  = 2'd2;
  localparam logic [1:0] SUB_CMPIU = 2'd3;
  localparam logic [1:0] SUB_SLL = 2'd0;
  localparam logic [1:0] SUB_SRA = 2'd1;
  localparam logic [1:0] SUB_SRL = 2'd2;
  localparam logic [1:0] SUB_MOD = 2'd3;

  localparam logic [15:0] PC_RESET   = 16'h8200;
  localparam logic [15:0] HALT_PC    = 16'h80FF;
  localparam logic [15:0] DATA_LO    = 16'h2000;
  localparam logic [15:0] DATA_LO_HI = 16'h7FFF;
  localparam logic [15:0] OS_LO      = 16'h8000;
  localparam logic [15:0] OS_HI      = 16'h9FFF;
  localparam logic [15:0] OS_DATA    = 16'hA000;
  localparam logic [2:0]  FLAGS_RESET = 3'd2;
  localparam logic [2:0]  FLAG_N = 3'd4;
  localparam logic [2:0]  FLAG_Z = 3'd2;
  localparam logic [2:0]  FLAG_P = 3'd1;
  localparam logic [2:0]  LINK_REG = 3'd7;

  typedef struct packed {
    status_t     status;
    logic        wr;
    logic [2:0]  wdst;
    logic [15:0] wval;
    logic        cmp;
    logic [2:0]  cmp_flags;
    logic        st;
    logic [15:0] mem_addr;
    logic [15:0] sval;
    logic [15:0] nxt;
    logic        newpriv;
    logic        need_div;
    logic        is_mod;
    logic        is_ldr;
  } exec_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] store_value;
    logic [15:0] store_address;
    logic        store_enable;
    logic [2:0]  flags_value;
    logic        flags_write_enable;
    logic [15:0] reg_value;
    logic [2:0]  reg_destination;
    logic        reg_write_enable;
    logic [15:0] trace_instruction;
    logic [15:0] trace_pc;
  } result_t;

  function automatic logic [2:0] nzp(input logic [15:0] v);
    if (v == 16'd0) begin
      return FLAG_Z;
    end
    return v[15] ? FLAG_N : FLAG_P;
  endfunction

endpackage

FILE: rtl/cpu16_ram.sv
module cpu16_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/cpu16_div.sv
module cpu16_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] quot,
  output logic [15:0] rem
);

  logic        busy_r, busy_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [15:0] q_r, q_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] d_r, d_nxt;
  logic        done_r, done_nxt;
  logic [16:0] trial;

  // one quotient bit per cycle, restoring
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    done_nxt = 1'b0;
    trial    = {rem_r, q_r[15]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd0;
      q_nxt    = dividend;
      rem_nxt  = 16'd0;
      d_nxt    = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = 16'(trial - {1'b0, d_r});
        q_nxt   = {q_r[14:0], 1'b1};
      end else begin
        rem_nxt = trial[15:0];
        q_nxt   = {q_r[14:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd15) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = rem_r;

endmodule

FILE: rtl/cpu16_alu.sv
module cpu16_alu (
  input  logic [15:0]     pc,
  input  logic [15:0]     ir,
  input  logic [15:0]     rs,
  input  logic [15:0]     rt,
  input  logic [15:0]     rd,
  input  logic [2:0]      flags,
  input  logic            priv,
  output cpu16_pkg::exec_t e
);

  logic [3:0]  op;
  logic [2:0]  d;
  logic [15:0] pc1;
  logic [15:0] addr;
  logic [31:0] prod;
  logic [15:0] im7;
  logic        lt, eq;

  assign op   = ir[15:12];
  assign d    = ir[11:9];
  assign pc1  = pc + 16'd1;
  assign addr = rs + {{10{ir[5]}}, ir[5:0]};
  assign prod = rs * rt;
  assign im7  = {{9{ir[6]}}, ir[6:0]};

  always_comb begin
    case (ir[8:7])
      cpu16_pkg::SUB_CMP: begin
        lt = $signed(rd) < $signed(rt);
        eq = rd == rt;
      end
      cpu16_pkg::SUB_CMPU: begin
        lt = rd < rt;
        eq = rd == rt;
      end
      cpu16_pkg::SUB_CMPI: begin
        lt = $signed(rd) < $signed(im7);
        eq = rd == im7;
      end
      default: begin
        lt = rd < {9'd0, ir[6:0]};
        eq = rd == {9'd0, ir[6:0]};
      end
    endcase
  end

  always_comb begin
    e          = '0;
    e.status   = cpu16_pkg::ST_OK;
    e.nxt      = pc1;
    e.newpriv  = priv;
    e.mem_addr = addr;
    if ((pc >= cpu16_pkg::DATA_LO && pc <= cpu16_pkg::DATA_LO_HI) ||
        pc >= cpu16_pkg::OS_DATA) begin
      e.status = cpu16_pkg::ST_EXEC_DATA;
    end else if (pc >= cpu16_pkg::OS_LO && !priv) begin
      e.status = cpu16_pkg::ST_PRIV;
    end else if (pc == cpu16_pkg::HALT_PC) begin
      e.status = cpu16_pkg::ST_HALT;
    end else begin
      case (op)
        cpu16_pkg::OP_BR: begin
          if ((flags & d) != 3'd0) begin
            e.nxt = pc1 + {{7{ir[8]}}, ir[8:0]};
          end
        end
        cpu16_pkg::OP_ARITH: begin
          e.wr   = 1'b1;
          e.wdst = d;
          if (ir[5]) begin
            e.wval = rs + {{11{ir[4]}}, ir[4:0]};
          end else begin
            case (ir[4:3])
              cpu16_pkg::SUB_ADD: e.wval = rs + rt;
              cpu16_pkg::SUB_MUL: e.wval = prod[15:0];
              cpu16_pkg::SUB_SUB: e.wval = rs - rt;
              default:            e.need_div = 1'b1;
            endcase
          end
        end
        cpu16_pkg::OP_CMP: begin
          e.cmp       = 1'b1;
          e.cmp_flags = lt ? cpu16_pkg::FLAG_N : (eq ? cpu16_pkg::FLAG_Z : cpu16_pkg::FLAG_P);
        end
        cpu16_pkg::OP_JSR: begin
          e.wr   = 1'b1;
          e.wdst = cpu16_pkg::LINK_REG;
          e.wval = pc1;
          e.nxt  = ir[11] ? {pc[15], ir[10:0], 4'd0} : rs;
        end
        cpu16_pkg::OP_LOGIC: begin
          e.wr   = 1'b1;
          e.wdst = d;
          if (ir[5]) begin
            e.wval = rs & {{11{ir[4]}}, ir[4:0]};
          end else begin
            case (ir[4:3])
              cpu16_pkg::SUB_AND: e.wval = rs & rt;
              cpu16_pkg::SUB_NOT: e.wval = ~rs;
              cpu16_pkg::SUB_OR:  e.wval = rs | rt;
              default:            e.wval = rs ^ rt;
            endcase
          end
        end
        cpu16_pkg::OP_LDR, cpu16_pkg::OP_STR: begin
          if (addr >= cpu16_pkg::OS_DATA && !priv) begin
            e.status = cpu16_pkg::ST_PRIV;
          end else if (addr < cpu16_pkg::DATA_LO ||
                       (addr >= cpu16_pkg::OS_LO && addr <= cpu16_pkg::OS_HI)) begin
            e.status = (op == cpu16_pkg::OP_LDR) ? cpu16_pkg::ST_LOAD_FAULT
                                                 : cpu16_pkg::ST_STORE_FAULT;
          end else if (op == cpu16_pkg::OP_LDR) begin
            e.is_ldr = 1'b1;
            e.wr     = 1'b1;
            e.wdst   = d;
          end else begin
            e.st   = 1'b1;
            e.sval = rd;
          end
        end
        cpu16_pkg::OP_RTI: begin
          e.nxt     = rd;
          e.newpriv = 1'b0;
        end
        cpu16_pkg::OP_CONST: begin
          e.wr   = 1'b1;
          e.wdst = d;
          e.wval = {{7{ir[8]}}, ir[8:0]};
        end
        cpu16_pkg::OP_SHIFT: begin
          e.wr   = 1'b1;
          e.wdst = d;
          case (ir[5:4])
            cpu16_pkg::SUB_SLL: e.wval = rs << ir[3:0];
            cpu16_pkg::SUB_SRA: e.wval = 16'($signed(rs) >>> ir[3:0]);
            cpu16_pkg::SUB_SRL: e.wval = rs >> ir[3:0];
            default: begin
              e.need_div = 1'b1;
              e.is_mod   = 1'b1;
            end
          endcase
        end
        cpu16_pkg::OP_JMP: begin
          e.nxt = ir[11] ? pc1 + {{5{ir[10]}}, ir[10:0]} : rs;
        end
        cpu16_pkg::OP_HICONST: begin
          e.wr   = 1'b1;
          e.wdst = d;
          e.wval = {ir[7:0], rd[7:0]};
        end
        cpu16_pkg::OP_TRAP: begin
          e.wr      = 1'b1;
          e.wdst    = cpu16_pkg::LINK_REG;
          e.wval    = pc1;
          e.nxt     = {8'h80, ir[7:0]};
          e.newpriv = 1'b1;
        end
        default: begin
          e.status = cpu16_pkg::ST_BAD_OP;
        end
      endcase
    end
  end

endmodule

FILE: rtl/sixteen_bit_cpu_step_unit.sv
// Multicycle 16-bit processor step unit. Each input transfer either writes one word of
// main memory (in_tuser 0) or executes the instruction at the current PC (in_tuser 1),
// and each gives exactly one trace record on the output. Main memory and the register
// file sit in synchronous RAMs; after reset the unit sweeps main memory to zero, one
// word a cycle, MEMORY_WORDS (65536) words, before in_tready rises. A memory load
// skips to output; an instruction steps through fetch, three register-file reads,
// execute and output; LDR adds a load state, DIV and MOD a wait on the bit-serial
// divider. The output register lets the next transfer start while a record waits.
module sixteen_bit_cpu_step_unit #(
  parameter int MEMORY_WORDS = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // load_address[15:0], load_word[31:16]
  input  logic        in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  // trace_pc, trace_instruction, reg_write_enable, reg_destination, reg_value,
  // flags_write_enable, flags_value, store_enable, store_address, store_value,
  // status, zero pad
  output logic [95:0] out_tdata
);

  localparam int MEM_AW = $clog2(MEMORY_WORDS);

  cpu16_pkg::state_t  state_r, state_nxt;
  logic [MEM_AW-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [15:0]        pc_r, pc_nxt;
  logic               priv_r, priv_nxt;
  logic [2:0]         flags_r, flags_nxt;
  logic [7:0]         rf_valid_r, rf_valid_nxt;
  logic [2:0]         rf_raddr_r;
  logic [15:0]        ir_r, rs_r, rt_r, rd_r;
  cpu16_pkg::result_t res_r, res_nxt, out_r;
  logic               out_valid_r, out_valid_nxt;

  logic               in_xfer;
  logic               mem_we;
  logic [MEM_AW-1:0]  mem_waddr, mem_raddr;
  logic [15:0]        mem_wdata, mem_rdata;
  logic               rf_we;
  logic [2:0]         rf_waddr, rf_raddr;
  logic [15:0]        rf_wdata, rf_rdata, rf_val;
  logic               fin;
  logic [15:0]        fin_wval;
  logic               div_start, div_done;
  logic [15:0]        div_q, div_r;
  cpu16_pkg::exec_t   e;

  cpu16_ram #(.WIDTH(16), .DEPTH(MEMORY_WORDS)) u_mem (
    .clk(clk), .wr_en(mem_we), .wr_addr(mem_waddr), .wr_data(mem_wdata),
    .rd_addr(mem_raddr), .rd_data(mem_rdata)
  );

  cpu16_ram #(.WIDTH(16), .DEPTH(8)) u_rf (
    .clk(clk), .wr_en(rf_we), .wr_addr(rf_waddr), .wr_data(rf_wdata),
    .rd_addr(rf_raddr), .rd_data(rf_rdata)
  );

  cpu16_alu u_alu (
    .pc(pc_r), .ir(ir_r), .rs(rs_r), .rt(rt_r), .rd(rd_r),
    .flags(flags_r), .priv(priv_r), .e(e)
  );

  cpu16_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(rs_r), .divisor(rt_r),
    .done(div_done), .quot(div_q), .rem(div_r)
  );

  assign in_tready = (state_r == cpu16_pkg::S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign rf_val    = rf_valid_r[rf_raddr_r] ? rf_rdata : 16'd0;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cpu16_pkg::S_CLEAR: begin
        if (clr_cnt_r == MEM_AW'(MEMORY_WORDS - 1)) begin
          state_nxt = cpu16_pkg::S_IDLE;
        end
      end
      cpu16_pkg::S_IDLE: begin
        if (in_xfer) begin
          state_nxt = in_tuser ? cpu16_pkg::S_FETCH : cpu16_pkg::S_OUT;
        end
      end
      cpu16_pkg::S_FETCH: state_nxt = cpu16_pkg::S_RS;
      cpu16_pkg::S_RS:    state_nxt = cpu16_pkg::S_RT;
      cpu16_pkg::S_RT:    state_nxt = cpu16_pkg::S_RD;
      cpu16_pkg::S_RD:    state_nxt = cpu16_pkg::S_EXEC;
      cpu16_pkg::S_EXEC: begin
        if (e.status != cpu16_pkg::ST_OK) begin
          state_nxt = cpu16_pkg::S_OUT;
        end else if (e.need_div && rt_r != 16'd0) begin
          state_nxt = cpu16_pkg::S_DIV;
        end else if (e.is_ldr) begin
          state_nxt = cpu16_pkg::S_LOAD;
        end else begin
          state_nxt = cpu16_pkg::S_OUT;
        end
      end
      cpu16_pkg::S_DIV: begin
        if (div_done) begin
          state_nxt = cpu16_pkg::S_OUT;
        end
      end
      cpu16_pkg::S_LOAD: state_nxt = cpu16_pkg::S_OUT;
      cpu16_pkg::S_OUT: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = cpu16_pkg::S_IDLE;
        end
      end
      default: state_nxt = cpu16_pkg::S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    clr_cnt_nxt   = clr_cnt_r;
    mem_we        = 1'b0;
    mem_waddr     = clr_cnt_r;
    mem_wdata     = 16'd0;
    mem_raddr     = MEM_AW'(pc_r);
    rf_raddr      = ir_r[2:0];
    div_start     = 1'b0;
    fin           = 1'b0;
    fin_wval      = e.wval;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    pc_nxt        = pc_r;
    priv_nxt      = priv_r;
    flags_nxt     = flags_r;
    rf_we         = 1'b0;
    rf_waddr      = e.wdst;
    rf_wdata      = 16'd0;
    rf_valid_nxt  = rf_valid_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      cpu16_pkg::S_CLEAR: begin
        mem_we      = 1'b1;
        clr_cnt_nxt = clr_cnt_r + MEM_AW'(1);
      end
      cpu16_pkg::S_IDLE: begin
        if (in_xfer && !in_tuser) begin
          mem_we         = 1'b1;
          mem_waddr      = MEM_AW'(in_tdata[15:0]);
          mem_wdata      = in_tdata[31:16];
          res_nxt        = '0;
          res_nxt.status = cpu16_pkg::ST_LOADED;
        end
      end
      cpu16_pkg::S_FETCH: rf_raddr = mem_rdata[8:6];
      cpu16_pkg::S_RS:    rf_raddr = ir_r[2:0];
      cpu16_pkg::S_RT: begin
        rf_raddr = (ir_r[15:12] == cpu16_pkg::OP_RTI) ? cpu16_pkg::LINK_REG : ir_r[11:9];
      end
      cpu16_pkg::S_EXEC: begin
        mem_raddr = MEM_AW'(e.mem_addr);
        if (e.status != cpu16_pkg::ST_OK) begin
          fin = 1'b1;
        end else if (e.need_div) begin
          if (rt_r == 16'd0) begin
            fin      = 1'b1;
            fin_wval = 16'd0;
          end else begin
            div_start = 1'b1;
          end
        end else if (!e.is_ldr) begin
          fin = 1'b1;
        end
      end
      cpu16_pkg::S_DIV: begin
        fin      = div_done;
        fin_wval = e.is_mod ? div_r : div_q;
      end
      cpu16_pkg::S_LOAD: begin
        fin      = 1'b1;
        fin_wval = mem_rdata;
      end
      cpu16_pkg::S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase

    // commit and build the trace record
    if (fin) begin
      res_nxt                   = '0;
      res_nxt.trace_pc          = pc_r;
      res_nxt.trace_instruction = ir_r;
      res_nxt.status            = e.status;
      if (e.status == cpu16_pkg::ST_OK) begin
        pc_nxt   = e.nxt;
        priv_nxt = e.newpriv;
        if (e.wr) begin
          rf_we                    = 1'b1;
          rf_wdata                 = fin_wval;
          rf_valid_nxt[e.wdst]     = 1'b1;
          flags_nxt                = cpu16_pkg::nzp(fin_wval);
          res_nxt.reg_write_enable = 1'b1;
          res_nxt.reg_destination  = e.wdst;
          res_nxt.reg_value        = fin_wval;
        end else if (e.cmp) begin
          flags_nxt = e.cmp_flags;
        end
        res_nxt.flags_write_enable = e.wr || e.cmp;
        res_nxt.flags_value        = (e.wr || e.cmp) ? flags_nxt : 3'd0;
        if (e.st) begin
          mem_we                = 1'b1;
          mem_waddr             = MEM_AW'(e.mem_addr);
          mem_wdata             = e.sval;
          res_nxt.store_enable  = 1'b1;
          res_nxt.store_address = e.mem_addr;
          res_nxt.store_value   = e.sval;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cpu16_pkg::S_CLEAR;
      clr_cnt_r   <= '0;
      pc_r        <= cpu16_pkg::PC_RESET;
      priv_r      <= 1'b1;
      flags_r     <= cpu16_pkg::FLAGS_RESET;
      rf_valid_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      pc_r        <= pc_nxt;
      priv_r      <= priv_nxt;
      flags_r     <= flags_nxt;
      rf_valid_r  <= rf_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rf_raddr_r <= rf_raddr;
    res_r      <= res_nxt;
    if (state_r == cpu16_pkg::S_FETCH) begin
      ir_r <= mem_rdata;
    end
    if (state_r == cpu16_pkg::S_RS) begin
      rs_r <= rf_val;
    end
    if (state_r == cpu16_pkg::S_RT) begin
      rt_r <= rf_val;
    end
    if (state_r == cpu16_pkg::S_RD) begin
      rd_r <= rf_val;
    end
    if (state_r == cpu16_pkg::S_OUT && (!out_valid_r || out_tready)) begin
      out_r <= res_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_r};

  a_div_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == cpu16_pkg::S_DIV)
    else $error("divider finished outside the divide state");

  a_rf_write_valid: assert property (@(posedge clk) disable iff (!rst_n)
    rf_we |=> rf_valid_r[$past(rf_waddr)])
    else $error("register write did not mark the entry valid");

  a_loaded_no_trace: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_r.status == cpu16_pkg::ST_LOADED |->
      out_r.trace_pc == 16'd0 && !out_r.reg_write_enable && !out_r.store_enable)
    else $error("memory load record carries execution fields");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import cpu16_pkg::*;

  localparam int          LIMIT_CYCLES = 3_000_000;
  localparam int          RANDOM_ITEMS = 1800;
  localparam int          HOLD_CYCLES  = 500;
  localparam logic [3:0]  OP_UNUSED    = 4'd3;

  typedef struct packed {
    logic [15:0]      pc;
    logic             priv;
    logic [2:0]       nzp;
    logic [7:0][15:0] rf;
  } cpu_state_t;

  typedef enum logic [1:0] {K_LOAD, K_INSTR} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [15:0] addr;   // load address, or the PC the instruction runs at
    logic [15:0] word;
    bit          lit;    // expected record typed in below
    status_t     st;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tuser = 1'b0;
  logic [31:0] in_tdata = '0;
  logic        out_tready = 1'b0;
  wire         in_tready;
  wire         out_tvalid;
  wire  [95:0] out_tdata;

  cpu_state_t  cpu;
  logic [15:0] mem_model [0:65535];
  result_t     trace_q [$];
  int          errors = 0;
  int          n_sent = 0;
  int          n_checked = 0;
  int          cycles = 0;
  int          burst_left = 0;
  int          status_seen [8];
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;

  stim_row_t dir_tab [] = '{
    '{K_LOAD,  16'hFFFF, 16'hFFFF, 1'b1, ST_LOADED},
    '{K_LOAD,  16'h0000, 16'h0000, 1'b1, ST_LOADED},
    '{K_INSTR, 16'h8200, {OP_CONST, 3'd1, 9'h100}, 1'b0, ST_OK},
    '{K_INSTR, 16'h8201, {OP_HICONST, 3'd1, 1'b0, 8'h7F}, 1'b0, ST_OK},
    '{K_INSTR, 16'h8202, {OP_ARITH, 3'd2, 3'd1, 1'b0, SUB_DIV, 3'd0}, 1'b0, ST_OK},
    '{K_INSTR, 16'h8203, {OP_SHIFT, 3'd2, 3'd1, SUB_MOD, 4'd0}, 1'b0, ST_OK},
    '{K_INSTR, 16'h8204, {OP_CMP, 3'd1, SUB_CMPIU, 7'h7F}, 1'b0, ST_OK},
    '{K_INSTR, 16'h8205, {OP_CMP, 3'd1, SUB_CMP, 4'd0, 3'd2}, 1'b0, ST_OK},
    '{K_INSTR, 16'h8206, {OP_UNUSED, 12'h000}, 1'b1, ST_BAD_OP},
    '{K_INSTR, 16'h8206, {OP_SHIFT, 3'd3, 3'd1, SUB_SRA, 4'hF}, 1'b0, ST_OK},
    '{K_INSTR, 16'h8207, {OP_LDR, 3'd4, 3'd0, 6'd0}, 1'b1, ST_LOAD_FAULT},
    '{K_INSTR, 16'h8207, {OP_STR, 3'd1, 3'd0, 6'd0}, 1'b1, ST_STORE_FAULT},
    '{K_INSTR, 16'h8207, {OP_HICONST, 3'd5, 1'b0, 8'h20}, 1'b0, ST_OK},
    '{K_INSTR, 16'h8208, {OP_STR, 3'd1, 3'd5, 6'd0}, 1'b0, ST_OK},
    '{K_INSTR, 16'h8209, {OP_LDR, 3'd6, 3'd5, 6'd0}, 1'b0, ST_OK},
    '{K_INSTR, 16'h820A, {OP_TRAP, 4'd0, 8'h10}, 1'b0, ST_OK}
  };

  sixteen_bit_cpu_step_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAIL sixteen_bit_cpu_step_unit");
      $finish;
    end
  end

  function automatic logic [2:0] flags_of(input logic [15:0] v);
    if (v == 16'd0) return FLAG_Z;
    return v[15] ? FLAG_N : FLAG_P;
  endfunction

  function automatic logic [2:0] cmp3(input logic signed [16:0] x, input logic signed [16:0] y);
    if (x < y) return FLAG_N;
    return (x == y) ? FLAG_Z : FLAG_P;
  endfunction

  function automatic bit is_code_addr(input logic [15:0] a);
    return a < DATA_LO || (a >= OS_LO && a <= OS_HI);
  endfunction

  // true when execution can go on from here without getting stuck
  function automatic bit runnable(input logic [15:0] pc, input logic priv);
    return (pc < DATA_LO || (pc >= OS_LO && pc <= OS_HI && priv)) && pc != HALT_PC;
  endfunction

  function automatic void exec_step(input cpu_state_t s, input logic [15:0] ir,
                                    output cpu_state_t n, output result_t r);
    logic [15:0]        pc, rs, rt, rd, nxt, wval, a;
    logic [2:0]         d, wdst;
    logic               wr, newpriv;
    logic signed [15:0] rss;
    n = s;
    r = '0;
    pc = s.pc;
    r.trace_pc = pc;
    r.trace_instruction = ir;
    r.status = ST_OK;
    if ((pc >= DATA_LO && pc <= DATA_LO_HI) || pc >= OS_DATA) begin
      r.status = ST_EXEC_DATA;
      return;
    end
    if (pc >= OS_LO && pc <= OS_HI && !s.priv) begin
      r.status = ST_PRIV;
      return;
    end
    if (pc == HALT_PC) begin
      r.status = ST_HALT;
      return;
    end
    d = ir[11:9];
    rs = s.rf[ir[8:6]];
    rt = s.rf[ir[2:0]];
    rd = s.rf[d];
    rss = rs;
    nxt = pc + 16'd1;
    wr = 1'b0;
    wdst = d;
    wval = '0;
    newpriv = s.priv;
    a = rs + {{10{ir[5]}}, ir[5:0]};
    case (ir[15:12])
      OP_BR: begin
        if ((s.nzp & d) != 3'd0) nxt = pc + 16'd1 + {{7{ir[8]}}, ir[8:0]};
      end
      OP_ARITH: begin
        wr = 1'b1;
        if (ir[5]) begin
          wval = rs + {{11{ir[4]}}, ir[4:0]};
        end else begin
          case (ir[4:3])
            SUB_ADD: wval = rs + rt;
            SUB_MUL: wval = rs * rt;
            SUB_SUB: wval = rs - rt;
            default: wval = (rt == 16'd0) ? 16'd0 : rs / rt;
          endcase
        end
      end
      OP_CMP: begin
        case (ir[8:7])
          SUB_CMP:  n.nzp = cmp3({rd[15], rd}, {rt[15], rt});
          SUB_CMPU: n.nzp = cmp3({1'b0, rd}, {1'b0, rt});
          SUB_CMPI: n.nzp = cmp3({rd[15], rd}, {{10{ir[6]}}, ir[6:0]});
          default:  n.nzp = cmp3({1'b0, rd}, {10'd0, ir[6:0]});
        endcase
        r.flags_write_enable = 1'b1;
        r.flags_value = n.nzp;
      end
      OP_JSR: begin
        wr = 1'b1;
        wdst = LINK_REG;
        wval = pc + 16'd1;
        nxt = ir[11] ? {pc[15], ir[10:0], 4'd0} : rs;
      end
      OP_LOGIC: begin
        wr = 1'b1;
        if (ir[5]) begin
          wval = rs & {{11{ir[4]}}, ir[4:0]};
        end else begin
          case (ir[4:3])
            SUB_AND: wval = rs & rt;
            SUB_NOT: wval = ~rs;
            SUB_OR:  wval = rs | rt;
            default: wval = rs ^ rt;
          endcase
        end
      end
      OP_LDR: begin
        if (a >= OS_DATA && !s.priv) begin
          r.status = ST_PRIV;
          return;
        end
        if (is_code_addr(a)) begin
          r.status = ST_LOAD_FAULT;
          return;
        end
        wr = 1'b1;
        wval = mem_model[a];
      end
      OP_STR: begin
        if (a >= OS_DATA && !s.priv) begin
          r.status = ST_PRIV;
          return;
        end
        if (is_code_addr(a)) begin
          r.status = ST_STORE_FAULT;
          return;
        end
        r.store_enable = 1'b1;
        r.store_address = a;
        r.store_value = rd;
      end
      OP_RTI: begin
        nxt = s.rf[LINK_REG];
        newpriv = 1'b0;
      end
      OP_CONST: begin
        wr = 1'b1;
        wval = {{7{ir[8]}}, ir[8:0]};
      end
      OP_SHIFT: begin
        wr = 1'b1;
        case (ir[5:4])
          SUB_SLL: wval = rs << ir[3:0];
          SUB_SRA: wval = rss >>> ir[3:0];
          SUB_SRL: wval = rs >> ir[3:0];
          default: wval = (rt == 16'd0) ? 16'd0 : rs % rt;
        endcase
      end
      OP_JMP: begin
        nxt = ir[11] ? pc + 16'd1 + {{5{ir[10]}}, ir[10:0]} : rs;
      end
      OP_HICONST: begin
        wr = 1'b1;
        wval = {ir[7:0], rd[7:0]};
      end
      OP_TRAP: begin
        wr = 1'b1;
        wdst = LINK_REG;
        wval = pc + 16'd1;
        nxt = {8'h80, ir[7:0]};
        newpriv = 1'b1;
      end
      default: begin
        r.status = ST_BAD_OP;
        return;
      end
    endcase
    if (wr) begin
      n.rf[wdst] = wval;
      n.nzp = flags_of(wval);
      r.reg_write_enable = 1'b1;
      r.reg_destination = wdst;
      r.reg_value = wval;
      r.flags_write_enable = 1'b1;
      r.flags_value = n.nzp;
    end
    n.priv = newpriv;
    n.pc = nxt;
  endfunction

  // random instruction that does not strand the PC; fall back to a trap
  function automatic logic [15:0] pick_instr();
    logic [15:0] w;
    cpu_state_t  nx;
    result_t     r;
    for (int k = 0; k < 12; k++) begin
      w = 16'($urandom);
      exec_step(cpu, w, nx, r);
      if (r.status != ST_OK || runnable(nx.pc, nx.priv)) return w;
    end
    return {OP_TRAP, 4'd0, 8'($urandom_range(0, 254))};
  endfunction

  task automatic send(input logic act, input logic [15:0] addr, input logic [15:0] word,
                      input bit lit, input result_t lit_res);
    result_t    r;
    cpu_state_t nx;
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= {word, addr};
    do @(posedge clk); while (!in_tready);
    if (!act) begin
      mem_model[addr] = word;
      r = '0;
      r.status = ST_LOADED;
    end else begin
      exec_step(cpu, mem_model[cpu.pc], nx, r);
      cpu = nx;
      if (r.store_enable) mem_model[r.store_address] = r.store_value;
    end
    trace_q.push_back(lit ? lit_res : r);
    status_seen[r.status]++;
    n_sent++;
    if (n_sent >= 600) hold_req = 1'b1;
  endtask

  task automatic run_instr(input logic [15:0] w, input bit lit, input result_t lit_res);
    send(1'b0, cpu.pc, w, 1'b0, '0);
    send(1'b1, 16'($urandom), 16'($urandom), lit, lit_res);
  endtask

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    errors++;
    if (errors <= 40)
      $display("mismatch %s record %0d: got %h want %h", what, n_checked, got, want);
  endtask

  task automatic compare(input string what, input logic [15:0] got, input logic [15:0] want);
    if (got !== want) report(what, got, want);
  endtask

  // receiver: stall pattern picked at random and repicked at random intervals, one long hold-off
  initial begin
    int mode;
    @(posedge clk);
    wait (rst_n);
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(16, 96)) begin
        @(posedge clk);
        if (hold_req && !hold_done) begin
          hold_done = 1'b1;
          for (int k = 0; k < HOLD_CYCLES; k++) begin
            out_tready <= 1'b0;
            @(posedge clk);
          end
        end
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[$bits(result_t)-1:0];
      if (trace_q.size() == 0) begin
        report("unexpected transfer", got.trace_pc, '0);
      end else begin
        want = trace_q.pop_front();
        compare("trace_pc", got.trace_pc, want.trace_pc);
        compare("trace_instruction", got.trace_instruction, want.trace_instruction);
        compare("reg_write_enable", 16'(got.reg_write_enable), 16'(want.reg_write_enable));
        compare("reg_destination", 16'(got.reg_destination), 16'(want.reg_destination));
        compare("reg_value", got.reg_value, want.reg_value);
        compare("flags_write_enable", 16'(got.flags_write_enable),
                16'(want.flags_write_enable));
        compare("flags_value", 16'(got.flags_value), 16'(want.flags_value));
        compare("store_enable", 16'(got.store_enable), 16'(want.store_enable));
        compare("store_address", got.store_address, want.store_address);
        compare("store_value", got.store_value, want.store_value);
        compare("status", 16'(got.status), 16'(want.status));
      end
      n_checked++;
    end
  end

  initial begin
    result_t lr;
    int      pick;
    cpu_state_t nx;
    result_t    r;
    for (int i = 0; i < 65536; i++) mem_model[i] = '0;
    for (int i = 0; i < 8; i++) status_seen[i] = 0;
    cpu.pc = PC_RESET;
    cpu.priv = 1'b1;
    cpu.nzp = FLAGS_RESET;
    cpu.rf = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      lr = '0;
      lr.status = dir_tab[i].st;
      if (dir_tab[i].kind == K_LOAD) begin
        send(1'b0, dir_tab[i].addr, dir_tab[i].word, dir_tab[i].lit, lr);
      end else begin
        lr.trace_pc = dir_tab[i].addr;
        lr.trace_instruction = dir_tab[i].word;
        run_instr(dir_tab[i].word, dir_tab[i].lit, lr);
      end
    end

    // mostly load-then-run at the PC, with stray loads and reruns of what is there
    while (n_sent < RANDOM_ITEMS + 30) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        send(1'b0, 16'($urandom), 16'($urandom), 1'b0, '0);
      end else if (pick == 1) begin
        exec_step(cpu, mem_model[cpu.pc], nx, r);
        if (r.status != ST_OK || runnable(nx.pc, nx.priv))
          send(1'b1, 16'($urandom), 16'($urandom), 1'b0, '0);
        else
          run_instr(pick_instr(), 1'b0, '0);
      end else begin
        run_instr(pick_instr(), 1'b0, '0);
      end
    end

    // end in one of the stuck states: halt, running data, or user mode in OS code
    run_instr({OP_TRAP, 4'd0, 8'h40}, 1'b0, '0);
    case ($urandom_range(0, 2))
      0: run_instr({OP_TRAP, 4'd0, 8'hFF}, 1'b0, '0);
      1: begin
        run_instr({OP_CONST, 3'd0, 9'h000}, 1'b0, '0);
        run_instr({OP_HICONST, 3'd0, 1'b0, 8'hA0}, 1'b0, '0);
        run_instr({OP_JMP, 3'd0, 3'd0, 6'd0}, 1'b0, '0);
      end
      default: begin
        run_instr({OP_CONST, LINK_REG, 9'h000}, 1'b0, '0);
        run_instr({OP_HICONST, LINK_REG, 1'b0, 8'h80}, 1'b0, '0);
        run_instr({OP_RTI, 12'h000}, 1'b0, '0);
      end
    endcase
    send(1'b1, 16'hFFFF, 16'hFFFF, 1'b0, '0);
    send(1'b1, 16'h0000, 16'h0000, 1'b0, '0);
    in_tvalid <= 1'b0;

    wait (trace_q.size() == 0);
    repeat (40) @(posedge clk);
    $display("covered %0d transfers in, %0d trace records checked, %0d mismatches",
             n_sent, n_checked, errors);
    $display("status mix ok/halt/data/priv/ldf/stf/badop/load: %0d %0d %0d %0d %0d %0d %0d %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5], status_seen[6], status_seen[7]);
    if (errors == 0) begin
      $display("PASS sixteen_bit_cpu_step_unit");
    end else begin
      $display("FAIL sixteen_bit_cpu_step_unit");
    end
    $finish;
  end

endmodule
